// ===== rtl/text_console_cursor_engine_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the text console cursor engine
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, skipped while reset is asserted
`define TCCE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcce: assertion failed");
// clocked check that also holds during reset
`define TCCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tcce: assertion failed");
`else
`define TCCE_ASSERT(label, clk, rst_n, prop)
`define TCCE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/tcce_pkg.sv =====
// ---------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ---------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    // input opcodes
    localparam logic [1:0] OP_TEXT   = 2'd0;
    localparam logic [1:0] OP_SETCUR = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // queued action kinds
    localparam logic [1:0] ACT_GLYPH   = 2'd0;
    localparam logic [1:0] ACT_NEWLINE = 2'd1;
    localparam logic [1:0] ACT_SETCUR  = 2'd2;
    localparam logic [1:0] ACT_CLEAR   = 2'd3;

    localparam logic [7:0] LEAD_LO  = 8'd195;
    localparam logic [7:0] LEAD_HI  = 8'd214;
    localparam logic [7:0] CONT_LO  = 8'd128;
    localparam logic [7:0] CONT_HI  = 8'd191;
    localparam logic [7:0] PRINT_LO = 8'd32;
    localparam logic [7:0] PRINT_HI = 8'd127;
    localparam logic [7:0] CH_QMARK = 8'd63;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam int MAX_ACTS = 4;

    // one pending step; for ACT_SETCUR page holds the column, chr the row
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] page;
        logic [7:0] chr;
        logic       flip;
    } t_act;

    typedef struct packed {
        t_act [MAX_ACTS-1:0] acts;
        logic [2:0]          count;
        logic                pend_valid;
        logic [7:0]          pend_lead;
    } t_dec;

    // result fields, draw_glyph in bit 0
    typedef struct packed {
        logic       clear_screen;
        logic       scroll_up;
        logic       flipped;
        logic [7:0] cell_row;
        logic [7:0] cell_col;
        logic [7:0] glyph_char;
        logic [7:0] glyph_page;
        logic       draw_glyph;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/text_console_cursor_engine.sv =====
// ---------------------------------------------------------------------------
// text_console_cursor_engine
// Text byte stream to glyph-cell commands with cursor, wrap and scroll.
// ---------------------------------------------------------------------------
// Usage:
//   s_* stream carries items: s_tuser = op, s_tdata = byte, col, row.
//   m_* stream carries cell commands; m_tlast marks the last one of an item.
//   APB port: register 0 columns (0x0, reset 80), register 1 rows (0x4,
//   reset 25). Write only while the block is idle.
// Path: an accepted item is decoded straight into the action queue; the
//   cursor step then takes the queue head and loads each result into the
//   output register that drives m_tvalid.
// Throughput: the cursor step unit handles one action per cycle while the
//   output register can take its result. Most items give 1 result, a tab 3,
//   a stray lead followed by a tab up to 4. Lead bytes and ignored ops
//   take no step; set cursor takes a step without a result.
// Reset (synchronous, active low): cursor home, no lead held, queue and
//   output register empty, registers back to 80 x 25.
// Stall: while m_tready is low a full output register holds and the queue
//   stops at its next result; s_tready drops as soon as the queue cannot empty this cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int RESET_COLUMNS = 80,
    parameter int RESET_ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // byte_value[7:0], col[15:8], row[23:16]
    input  wire logic [1:0]  s_tuser,  // op[1:0]
    // cell commands
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // draw_glyph[0], glyph_page[8:1],
                                       // glyph_char[16:9], cell_col[24:17],
                                       // cell_row[32:25], flipped[33],
                                       // scroll_up[34], clear_screen[35]
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "text_console_cursor_engine_assert.svh"

    // config registers
    logic [7:0] r_columns;
    logic [7:0] r_rows;
    logic       cfg_wr;

    // cursor and held lead
    logic [7:0] r_cur_col;
    logic [7:0] r_cur_row;
    logic       r_pend_valid;
    logic [7:0] r_pend_lead;

    // action queue, head at index 0
    t_act [MAX_ACTS-1:0] r_acts;
    logic [2:0]          r_nact;

    // output register
    logic       r_ov;
    t_res       r_res;
    logic       r_last;

    t_dec       dec;
    t_res       step_res;
    logic       step_emit;
    logic [7:0] n_cur_col;
    logic [7:0] n_cur_row;
    logic       out_free;
    logic       step_fire;
    logic       s_acc;

    // -------------------------------------------------------------------
    // APB: register select by paddr[2]
    // -------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = {24'd0, (paddr[2] ? r_rows : r_columns)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 8'(RESET_COLUMNS);
            r_rows    <= 8'(RESET_ROWS);
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_rows <= pwdata[7:0];
            end else begin
                r_columns <= pwdata[7:0];
            end
        end
    end

    // -------------------------------------------------------------------
    // Decode of the incoming item
    // -------------------------------------------------------------------
    tcce_decode u_decode (
        .i_op         (s_tuser),
        .i_byte       (s_tdata[7:0]),
        .i_col        (s_tdata[15:8]),
        .i_row        (s_tdata[23:16]),
        .i_pend_valid (r_pend_valid),
        .i_pend_lead  (r_pend_lead),
        .o_dec        (dec)
    );

    // -------------------------------------------------------------------
    // Cursor step on the queue head
    // -------------------------------------------------------------------
    tcce_step u_step (
        .i_act     (r_acts[0]),
        .i_cur_col (r_cur_col),
        .i_cur_row (r_cur_row),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .o_res     (step_res),
        .o_emit    (step_emit),
        .o_col_n   (n_cur_col),
        .o_row_n   (n_cur_row)
    );

    assign out_free  = !r_ov || m_tready;
    // set cursor gives no result, so it never waits on the output side
    assign step_fire = (r_nact != 3'd0) && (out_free || !step_emit);
    // take a new item once the queue empties in this cycle
    assign s_tready  = (r_nact == 3'd0) || ((r_nact == 3'd1) && step_fire);
    assign s_acc     = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nact       <= 3'd0;
            r_pend_valid <= 1'b0;
            r_pend_lead  <= 8'd0;
            r_cur_col    <= 8'd0;
            r_cur_row    <= 8'd0;
            r_ov         <= 1'b0;
        end else begin
            if (s_acc) begin
                r_nact       <= dec.count;
                r_pend_valid <= dec.pend_valid;
                r_pend_lead  <= dec.pend_lead;
            end else if (step_fire) begin
                r_nact <= r_nact - 3'd1;
            end
            if (step_fire) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
            end
            if (step_fire && step_emit) begin
                r_ov <= 1'b1;
            end else if (m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload: queue contents and result register
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_acts <= dec.acts;
        end else if (step_fire) begin
            r_acts <= {t_act'('0), r_acts[MAX_ACTS-1:1]};
        end
        if (step_fire && step_emit) begin
            r_res  <= step_res;
            r_last <= (r_nact == 3'd1);
        end
    end

    assign m_tvalid = r_ov;
    assign m_tdata  = {4'd0, r_res};
    assign m_tlast  = r_last;

    // -------------------------------------------------------------------
    // Checks
    // -------------------------------------------------------------------
    `TCCE_ASSERT(a_queue_depth, i_clk, i_rst_n, r_nact <= 3'd4)
    `TCCE_ASSERT(a_accept_drains, i_clk, i_rst_n, s_acc |-> (r_nact <= 3'd1))
    `TCCE_ASSERT(a_lead_range, i_clk, i_rst_n,
        r_pend_valid |-> (r_pend_lead >= LEAD_LO && r_pend_lead <= LEAD_HI))
    `TCCE_ASSERT(a_clear_no_glyph, i_clk, i_rst_n,
        (r_ov && r_res.clear_screen) |-> (!r_res.draw_glyph && r_last))
    `TCCE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!r_ov && r_nact == 3'd0))

endmodule

`default_nettype wire

// ===== rtl/tcce_decode.sv =====
// ---------------------------------------------------------------------------
// tcce_decode
// Turns one input item into a short list of cursor actions and updates
// the held lead byte of a two-byte character.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_decode
    import tcce_pkg::*;
(
    input  wire logic [1:0] i_op,
    input  wire logic [7:0] i_byte,
    input  wire logic [7:0] i_col,
    input  wire logic [7:0] i_row,
    input  wire logic       i_pend_valid,
    input  wire logic [7:0] i_pend_lead,
    output t_dec            o_dec
);

    t_act [MAX_ACTS-1:0] sl;
    logic [2:0]          sn;
    t_act                qmark;
    logic                is_lead;
    logic                is_cont;

    assign is_lead = (i_byte >= LEAD_LO) && (i_byte <= LEAD_HI);
    assign is_cont = (i_byte >= CONT_LO) && (i_byte <= CONT_HI);
    assign qmark   = '{kind: ACT_GLYPH, page: 8'd0, chr: CH_QMARK, flip: 1'b1};

    // actions of a byte handled on its own
    always_comb begin
        sl = '0;
        sn = 3'd1;
        if (i_byte >= PRINT_LO && i_byte <= PRINT_HI) begin
            sl[0] = '{kind: ACT_GLYPH, page: 8'd0, chr: i_byte, flip: 1'b0};
        end else if (i_byte == CH_NL) begin
            sl[0] = '{kind: ACT_NEWLINE, page: 8'd0, chr: 8'd0, flip: 1'b0};
        end else if (i_byte == CH_TAB) begin
            sl[0] = '{kind: ACT_GLYPH, page: 8'd0, chr: CH_SPACE, flip: 1'b0};
            sl[1] = sl[0];
            sl[2] = sl[0];
            sn    = 3'd3;
        end else begin
            sl[0] = qmark;
        end
    end

    always_comb begin
        o_dec            = '0;
        o_dec.pend_valid = i_pend_valid;
        o_dec.pend_lead  = i_pend_lead;
        case (i_op)
            OP_TEXT: begin
                if (i_pend_valid) begin
                    o_dec.pend_valid = 1'b0;
                    o_dec.pend_lead  = 8'd0;
                    if (is_cont) begin
                        o_dec.acts[0] = '{kind: ACT_GLYPH, page: i_pend_lead,
                                          chr: i_byte, flip: 1'b0};
                        o_dec.count   = 3'd1;
                    end else begin
                        // stray lead: flipped '?' first
                        o_dec.acts[0] = qmark;
                        if (is_lead) begin
                            o_dec.count      = 3'd1;
                            o_dec.pend_valid = 1'b1;
                            o_dec.pend_lead  = i_byte;
                        end else begin
                            o_dec.acts[MAX_ACTS-1:1] = sl[MAX_ACTS-2:0];
                            o_dec.count              = sn + 3'd1;
                        end
                    end
                end else if (is_lead) begin
                    o_dec.pend_valid = 1'b1;
                    o_dec.pend_lead  = i_byte;
                end else begin
                    o_dec.acts  = sl;
                    o_dec.count = sn;
                end
            end
            OP_SETCUR: begin
                o_dec.acts[0] = '{kind: ACT_SETCUR, page: i_col, chr: i_row, flip: 1'b0};
                o_dec.count   = 3'd1;
            end
            OP_CLEAR: begin
                o_dec.acts[0] = '{kind: ACT_CLEAR, page: 8'd0, chr: 8'd0, flip: 1'b0};
                o_dec.count   = 3'd1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcce_step.sv =====
// ---------------------------------------------------------------------------
// tcce_step
// Applies one action to the cursor: wrap, line move, scroll and the
// result it produces.
// ---------------------------------------------------------------------------
`default_nettype none

module tcce_step
    import tcce_pkg::*;
(
    input  wire t_act       i_act,
    input  wire logic [7:0] i_cur_col,
    input  wire logic [7:0] i_cur_row,
    input  wire logic [7:0] i_columns,
    input  wire logic [7:0] i_rows,
    output t_res            o_res,
    output logic            o_emit,
    output logic [7:0]      o_col_n,
    output logic [7:0]      o_row_n
);

    logic [8:0] row_inc;
    logic       nl_scroll;
    logic [7:0] nl_row;
    logic       wrap;

    // next-line move: past the last row the screen scrolls instead
    assign row_inc   = {1'b0, i_cur_row} + 9'd1;
    assign nl_scroll = row_inc >= {1'b0, i_rows};
    assign nl_row    = nl_scroll ? i_cur_row : row_inc[7:0];
    assign wrap      = i_cur_col >= i_columns;

    always_comb begin
        o_res   = '0;
        o_emit  = 1'b0;
        o_col_n = i_cur_col;
        o_row_n = i_cur_row;
        unique case (i_act.kind)
            ACT_GLYPH: begin
                o_emit           = 1'b1;
                o_res.draw_glyph = 1'b1;
                o_res.glyph_page = i_act.page;
                o_res.glyph_char = i_act.chr;
                o_res.flipped    = i_act.flip;
                if (wrap) begin
                    o_res.cell_col  = 8'd0;
                    o_res.cell_row  = nl_row;
                    o_res.scroll_up = nl_scroll;
                    o_col_n         = 8'd1;
                    o_row_n         = nl_row;
                end else begin
                    o_res.cell_col = i_cur_col;
                    o_res.cell_row = i_cur_row;
                    o_col_n        = i_cur_col + 8'd1;
                end
            end
            ACT_NEWLINE: begin
                o_emit          = 1'b1;
                o_res.cell_col  = 8'd0;
                o_res.cell_row  = nl_row;
                o_res.scroll_up = nl_scroll;
                o_col_n         = 8'd0;
                o_row_n         = nl_row;
            end
            ACT_SETCUR: begin
                if (i_act.page < i_columns && i_act.chr < i_rows) begin
                    o_col_n = i_act.page;
                    o_row_n = i_act.chr;
                end
            end
            ACT_CLEAR: begin
                o_emit             = 1'b1;
                o_res.clear_screen = 1'b1;
                o_col_n            = 8'd0;
                o_row_n            = 8'd0;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== bench/text_console_cursor_engine_tb.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb
// Self-checking bench for the cursor engine: text, set-cursor and clear items
// go in on the s_ stream, and every cell command on the m_ stream is checked
// field by field against a cursor/wrap/scroll predictor kept in the bench.
// A directed table comes first, then random traffic over several screen
// geometries, including the 1x1 and 255x255 corners.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    // op code the block ignores
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    // register indexes; byte address is 4 * index
    localparam int         REG_COLUMNS = 0;
    localparam int         REG_ROWS    = 1;
    // enough cycles for the decode and step stages to drain an item
    localparam int         DRAIN_CYCLES = 8;
    localparam int         MAX_REPORTS  = 10;

    // one item on the input stream; want is only used when typed is set
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
        logic       typed;
        t_res       want;
    } t_stim_row;

    // one cell command as it should leave the block
    typedef struct packed {
        logic last;
        t_res res;
    } t_cell_cmd;

    localparam t_res NO_CELL = '0;
    localparam t_res CLEARED = 36'h8_0000_0000;  // clear_screen only

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs; everything known from time zero
    // ------------------------------------------------------------------------
    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;  // ch[7:0], col[15:8], row[23:16]
    logic [1:0]  s_tuser  = OP_TEXT;  // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;  // draw_glyph, glyph_page, glyph_char, cell_col,
                           // cell_row, flipped, scroll_up, clear_screen
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_cursor_engine DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Cursor predictor state. Row math is kept wider than 8 bits because a
    // line move briefly reaches row 255 before it is pulled back by a scroll.
    // ------------------------------------------------------------------------
    logic [7:0]  num_cols = 8'd80;
    logic [7:0]  num_rows = 8'd25;
    int unsigned cur_col  = 0;
    int unsigned cur_row  = 0;
    logic [7:0]  held_lead  = 8'd0;
    logic        held_valid = 1'b0;

    t_cell_cmd   pending_cells[$];  // cell commands still owed by the block
    int          mismatch_count = 0;
    int          cells_seen     = 0;
    int          src_gap_max    = 18;
    int          sink_gap_max   = 18;

    function automatic void queue_cell(logic draw, logic [7:0] page, logic [7:0] ch,
                                       int unsigned c, int unsigned r, logic flip,
                                       logic scroll, logic clr);
        t_cell_cmd cmd;
        cmd.last             = 1'b0;
        cmd.res.draw_glyph   = draw;
        cmd.res.glyph_page   = page;
        cmd.res.glyph_char   = ch;
        cmd.res.cell_col     = c[7:0];
        cmd.res.cell_row     = r[7:0];
        cmd.res.flipped      = flip;
        cmd.res.scroll_up    = scroll;
        cmd.res.clear_screen = clr;
        pending_cells.push_back(cmd);
    endfunction

    // carriage return plus line feed; scrolls when leaving the last row
    function automatic logic advance_line();
        logic scroll;
        scroll  = 1'b0;
        cur_col = 0;
        cur_row = (cur_row + 1) & 'h1FF;
        if (cur_row + 1 > num_rows) begin
            cur_row = (cur_row - 1) & 'hFF;
            scroll  = 1'b1;
        end
        return scroll;
    endfunction

    // wrap is lazy: only a glyph that would start past the edge moves down
    function automatic void place_glyph(logic [7:0] page, logic [7:0] ch, logic flip);
        logic scroll;
        scroll = 1'b0;
        if (cur_col + 1 > num_cols) scroll = advance_line();
        queue_cell(1'b1, page, ch, cur_col, cur_row, flip, scroll, 1'b0);
        cur_col = (cur_col + 1) & 'hFF;
    endfunction

    function automatic void place_byte(logic [7:0] b);
        logic scroll;
        if (b >= PRINT_LO && b <= PRINT_HI) begin
            place_glyph(8'd0, b, 1'b0);
        end else if (b == CH_NL) begin
            scroll = advance_line();
            queue_cell(1'b0, 8'd0, 8'd0, cur_col, cur_row, 1'b0, scroll, 1'b0);
        end else if (b == CH_TAB) begin
            repeat (3) place_glyph(8'd0, CH_SPACE, 1'b0);
        end else begin
            place_glyph(8'd0, CH_QMARK, 1'b1);
        end
    endfunction

    // works out the cell commands of one accepted item; returns their count
    function automatic int place_item(logic [1:0] op, logic [7:0] b,
                                      logic [7:0] c, logic [7:0] r);
        int        first;
        logic      is_lead;
        t_cell_cmd tail;
        first   = pending_cells.size();
        is_lead = (b >= LEAD_LO && b <= LEAD_HI);
        case (op)
            OP_TEXT: begin
                if (held_valid && b >= CONT_LO && b <= CONT_HI) begin
                    place_glyph(held_lead, b, 1'b0);
                    held_valid = 1'b0;
                    held_lead  = 8'd0;
                end else begin
                    // a held lead without its continuation is unknown
                    if (held_valid) place_glyph(8'd0, CH_QMARK, 1'b1);
                    held_valid = is_lead;
                    held_lead  = is_lead ? b : 8'd0;
                    if (!is_lead) place_byte(b);
                end
            end
            OP_SETCUR: begin
                // out-of-range requests are dropped; held lead survives
                if (c + 1 <= num_cols && r + 1 <= num_rows) begin
                    cur_col = c;
                    cur_row = r;
                end
            end
            OP_CLEAR: begin
                cur_col = 0;
                cur_row = 0;
                queue_cell(1'b0, 8'd0, 8'd0, 0, 0, 1'b0, 1'b0, 1'b1);
            end
            default: ;  // unused op: no effect
        endcase
        if (pending_cells.size() > first) begin
            tail      = pending_cells.pop_back();
            tail.last = 1'b1;
            pending_cells.push_back(tail);
        end
        return pending_cells.size() - first;
    endfunction

    function automatic t_res glyph_at(logic [7:0] ch, logic [7:0] c, logic [7:0] r,
                                      logic flip);
        t_res g;
        g            = NO_CELL;
        g.draw_glyph = 1'b1;
        g.glyph_char = ch;
        g.cell_col   = c;
        g.cell_row   = r;
        g.flipped    = flip;
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table, run at the reset geometry of 80 x 25. Rows with typed
    // set carry their expected cell; the rest go through the predictor.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [0:26] = '{
        '{OP_TEXT,   8'd65,  8'h00, 8'hFF, 1'b1, glyph_at(8'd65,  8'd0, 8'd0, 1'b0)},
        '{OP_TEXT,   8'd127, 8'hFF, 8'h00, 1'b1, glyph_at(8'd127, 8'd1, 8'd0, 1'b0)},
        // control byte and top byte: both unknown, drawn as flipped '?'
        '{OP_TEXT,   8'd0,   8'h55, 8'hAA, 1'b1, glyph_at(CH_QMARK, 8'd2, 8'd0, 1'b1)},
        '{OP_TEXT,   8'd255, 8'hAA, 8'h55, 1'b1, glyph_at(CH_QMARK, 8'd3, 8'd0, 1'b1)},
        '{OP_TEXT,   8'd31,  8'h00, 8'h00, 1'b0, NO_CELL},  // just below printable
        '{OP_TEXT,   CH_TAB, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   CH_NL,  8'h00, 8'h00, 1'b0, NO_CELL},
        // lowest lead with lowest continuation, highest with highest
        '{OP_TEXT,   8'd195, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   8'd128, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   8'd214, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   8'd191, 8'h00, 8'h00, 1'b0, NO_CELL},
        // lead after lead: the first one is unknown, the second is held
        '{OP_TEXT,   8'd200, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   8'd210, 8'h00, 8'h00, 1'b0, NO_CELL},
        // stray lead, then a byte just past the continuation range
        '{OP_TEXT,   8'd192, 8'h00, 8'h00, 1'b0, NO_CELL},
        // stray lead followed by a tab: four cells from one item
        '{OP_TEXT,   8'd195, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   CH_TAB, 8'h00, 8'h00, 1'b0, NO_CELL},
        // stray lead followed by a newline
        '{OP_TEXT,   8'd196, 8'h00, 8'h00, 1'b0, NO_CELL},
        '{OP_TEXT,   CH_NL,  8'h00, 8'h00, 1'b0, NO_CELL},
        // bottom-right cell, then a glyph that wraps and scrolls
        '{OP_SETCUR, 8'h00,  8'd79,  8'd24,  1'b0, NO_CELL},
        '{OP_TEXT,   8'd66,  8'h00,  8'h00,  1'b0, NO_CELL},
        '{OP_TEXT,   8'd67,  8'h00,  8'h00,  1'b0, NO_CELL},
        // out-of-range cursor requests are ignored
        '{OP_SETCUR, 8'hFF,  8'd80,  8'd0,   1'b0, NO_CELL},
        '{OP_SETCUR, 8'h00,  8'd255, 8'd255, 1'b0, NO_CELL},
        '{OP_UNUSED, 8'hFF,  8'hFF,  8'hFF,  1'b0, NO_CELL},
        // clear keeps a held lead; its continuation lands at home
        '{OP_TEXT,   8'd205, 8'h00,  8'h00,  1'b0, NO_CELL},
        '{OP_CLEAR,  8'hFF,  8'hFF,  8'hFF,  1'b1, CLEARED},
        '{OP_TEXT,   8'd130, 8'h00,  8'h00,  1'b0, NO_CELL}
    };

    // ------------------------------------------------------------------------
    // Input side: random gap, then hold the item until the handshake. The
    // valid stays high across back-to-back items.
    // ------------------------------------------------------------------------
    task automatic send_item(input t_stim_row item);
        int gap;
        int made;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tdata  = {item.row, item.col, item.ch};
        s_tuser  = item.op;
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        made = place_item(item.op, item.ch, item.col, item.row);
        if (item.typed) begin
            // the predictor still tracks state; the typed cell replaces its output
            repeat (made) void'(pending_cells.pop_back());
            pending_cells.push_back('{1'b1, item.want});
        end
        @(negedge i_clk);
    endtask

    task automatic random_burst(input int picks);
        t_stim_row it;
        int        pick;
        for (int i = 0; i < picks; i++) begin
            pick = $urandom_range(0, 99);
            it   = '{OP_TEXT, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NO_CELL};
            if (pick < 35) begin
                it.ch = 8'($urandom_range(PRINT_LO, PRINT_HI));
            end else if (pick < 55) begin
                // well-formed two-byte character
                it.ch = 8'($urandom_range(LEAD_LO, LEAD_HI));
                send_item(it);
                it.ch = 8'($urandom_range(CONT_LO, CONT_HI));
            end else if (pick < 62) begin
                it.ch = CH_TAB;
            end else if (pick < 70) begin
                it.ch = CH_NL;
            end else if (pick < 80) begin
                it.op = OP_SETCUR;
                // mostly legal positions so the cursor really moves around
                if ($urandom_range(0, 3) != 0) begin
                    it.col = 8'($urandom_range(0, num_cols - 1));
                    it.row = 8'($urandom_range(0, num_rows - 1));
                end
            end else if (pick < 86) begin
                it.op = OP_CLEAR;
            end else if (pick < 89) begin
                it.op = OP_UNUSED;
            end else if (pick < 94) begin
                // lone lead; whatever comes next decides if it is stray
                it.ch = 8'($urandom_range(LEAD_LO, LEAD_HI));
            end
            // otherwise: raw random byte as noise
            send_item(it);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall per item, check at the accepting edge
    // ------------------------------------------------------------------------
    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("cell %0d: %s expected %0d, got %0d", cells_seen, name, want, got);
        end
    endtask

    task automatic check_cell(input logic [39:0] data, input logic lst);
        t_cell_cmd want;
        t_res      got;
        got = data[35:0];
        if (pending_cells.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("cell %0d: unexpected cell command %h last %0b",
                         cells_seen, data, lst);
        end else begin
            want = pending_cells.pop_front();
            cmp_field("draw_glyph",   want.res.draw_glyph,   got.draw_glyph);
            cmp_field("glyph_page",   want.res.glyph_page,   got.glyph_page);
            cmp_field("glyph_char",   want.res.glyph_char,   got.glyph_char);
            cmp_field("cell_col",     want.res.cell_col,     got.cell_col);
            cmp_field("cell_row",     want.res.cell_row,     got.cell_row);
            cmp_field("flipped",      want.res.flipped,      got.flipped);
            cmp_field("scroll_up",    want.res.scroll_up,    got.scroll_up);
            cmp_field("clear_screen", want.res.clear_screen, got.clear_screen);
            cmp_field("last",         want.last,             lst);
        end
        cells_seen++;
    endtask

    initial begin : cell_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            check_cell(m_tdata, m_tlast);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Sequencing helpers
    // ------------------------------------------------------------------------
    // idle = nothing owed, plus time for items that make no cell to finish
    task automatic settle();
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // two APB writes: setup cycle, then access cycle
    task automatic set_geometry(input logic [7:0] cols, input logic [7:0] rws);
        for (int idx = REG_COLUMNS; idx <= REG_ROWS; idx++) begin
            psel    = 1'b1;
            penable = 1'b0;
            pwrite  = 1'b1;
            paddr   = 3'(4 * idx);
            pwdata  = {24'd0, (idx == REG_COLUMNS) ? cols : rws};
            @(negedge i_clk);
            penable = 1'b1;
            do @(posedge i_clk); while (!pready);
            if (idx == REG_COLUMNS) num_cols = cols;
            else num_rows = rws;
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
            pwrite  = 1'b0;
        end
    endtask

    function automatic int pick_gap_max();
        case ($urandom_range(0, 2))
            0: return 0;  // back-to-back stretch
            1: return 3;
            default: return 18;
        endcase
    endfunction

    task automatic run_phase(input logic [7:0] cols, input logic [7:0] rws);
        settle();
        set_geometry(cols, rws);
        src_gap_max  = pick_gap_max();
        sink_gap_max = pick_gap_max();
        random_burst(20);
        s_tvalid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);
        s_tvalid = 1'b0;

        // corners first: single cell, largest grid, single row, single column
        run_phase(8'd1, 8'd1);
        run_phase(8'd255, 8'd255);
        run_phase(8'd255, 8'd1);
        run_phase(8'd1, 8'd255);
        run_phase(8'($urandom_range(2, 8)), 8'($urandom_range(2, 8)));
        run_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));

        settle();
        if (mismatch_count == 0 && pending_cells.size() == 0) begin
            $display("text_console_cursor_engine regression: pass");
        end else begin
            $display("text_console_cursor_engine regression: fail");
        end
        $finish;
    end

    // hang guard, well above the slowest legal run
    initial begin
        #5_000_000;
        $display("text_console_cursor_engine regression: fail");
        $finish;
    end

endmodule
